### hw/rtl/ats_pkg.sv
package ats_pkg;

   localparam int VALUE_BITS = 32;
   localparam int COUNT_BITS = 8;
   localparam int ACC_BITS   = VALUE_BITS + 4;

   localparam int CH_W    = 8;
   localparam int KIND_W  = 3;
   localparam int VALUE_W = 32;
   localparam int INDEX_W = 8;

   localparam logic signed [ACC_BITS-1:0] ACC_MAX =
      {{(ACC_BITS - VALUE_BITS + 1){1'b0}}, {(VALUE_BITS - 1){1'b1}}};
   localparam logic signed [ACC_BITS-1:0] ACC_MIN = ~ACC_MAX;

   localparam logic [2:0] MODE_IDLE   = 3'd0;
   localparam logic [2:0] MODE_STRING = 3'd1;
   localparam logic [2:0] MODE_HEAP   = 3'd2;
   localparam logic [2:0] MODE_LOCAL  = 3'd3;
   localparam logic [2:0] MODE_NUMBER = 3'd4;

   localparam logic [KIND_W-1:0] KIND_FALSE    = 3'd0;
   localparam logic [KIND_W-1:0] KIND_TRUE     = 3'd1;
   localparam logic [KIND_W-1:0] KIND_NULL     = 3'd2;
   localparam logic [KIND_W-1:0] KIND_STR_CHAR = 3'd3;
   localparam logic [KIND_W-1:0] KIND_STR_END  = 3'd4;
   localparam logic [KIND_W-1:0] KIND_HEAP_REF = 3'd5;
   localparam logic [KIND_W-1:0] KIND_LOCAL_REF = 3'd6;
   localparam logic [KIND_W-1:0] KIND_INTEGER  = 3'd7;

   localparam logic [CH_W-1:0] CH_QUOTE   = 8'h22;
   localparam logic [CH_W-1:0] CH_AT      = 8'h40;
   localparam logic [CH_W-1:0] CH_DOLLAR  = 8'h24;
   localparam logic [CH_W-1:0] CH_MINUS   = 8'h2D;
   localparam logic [CH_W-1:0] CH_F       = 8'h46;
   localparam logic [CH_W-1:0] CH_T       = 8'h54;
   localparam logic [CH_W-1:0] CH_N       = 8'h4E;
   localparam logic [CH_W-1:0] CH_ZERO    = 8'h30;
   localparam logic [CH_W-1:0] CH_NINE    = 8'h39;
   localparam logic [CH_W-1:0] CH_SPACE   = 8'h20;
   localparam logic [CH_W-1:0] CH_NEWLINE = 8'h0A;

endpackage

### hw/rtl/argument_token_scanner_unit.sv
// Argument token scanner.
// req_ channel: one character beat per cycle while req_tready is high;
// req_tuser marks the first character of a line, which returns the scanner
// to idle and clears the argument count before that character is handled.
// rsp_ channel: zero or one token beat per character (booleans, null,
// string characters, string end, heap/local references, integers).
// Throughput: one character per cycle while rsp_tready is high or the
// result register is empty, set by the combinational mode update and
// multiply-by-ten accumulate between the input and result registers.
// Each token passes from the input register into the result register.
// Reset (synchronous, active high): both registers empty, scanner idle,
// argument count and number state cleared.
// Stall: while rsp_tready is low the result register holds its token; the
// input register keeps one character, and req_tready drops once both are
// full. No beat is lost or repeated.
module argument_token_scanner_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] ch
   input  logic [0:0]  req_tuser,   // [0] line_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] value, [39:32] arg_index
   output logic [3:0]  rsp_tuser    // [2:0] kind, [3] saturated
);
   import ats_pkg::*;

   logic                         in_valid_ff, in_valid_in;
   logic [CH_W-1:0]              ch_ff;
   logic                         line_start_ff;

   logic [2:0]                   mode_ff, mode_in;
   logic signed [VALUE_BITS-1:0] accum_ff, accum_in;
   logic                         neg_ff, neg_in;
   logic                         clip_ff, clip_in;
   logic                         seen_ff, seen_in;
   logic [COUNT_BITS-1:0]        count_ff, count_in;

   logic                         out_valid_ff, out_valid_in;
   logic [KIND_W-1:0]            kind_ff, kind_in;
   logic [VALUE_W-1:0]           value_ff, value_in;
   logic [INDEX_W-1:0]           index_ff;
   logic                         sat_ff, sat_in;

   logic                         out_free;
   logic                         process;
   logic                         emit;
   logic                         finish;

   logic [2:0]                   mode_c;
   logic [COUNT_BITS-1:0]        count_c;
   logic signed [VALUE_BITS-1:0] accum_c;
   logic                         neg_c, clip_c, seen_c;

   logic signed [9:0]            digit;
   logic signed [9:0]            term;
   logic signed [ACC_BITS-1:0]   acc_x, mul_x, scaled_x, sum_x;
   logic                         take_acc;
   logic                         is_digit;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign process    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || process;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (process) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      mode_c  = line_start_ff ? MODE_IDLE : mode_ff;
      count_c = line_start_ff ? '0 : count_ff;
      if (line_start_ff || mode_c == MODE_IDLE) begin
         accum_c = '0;
         neg_c   = 1'b0;
         clip_c  = 1'b0;
         seen_c  = 1'b0;
      end else begin
         accum_c = accum_ff;
         neg_c   = neg_ff;
         clip_c  = clip_ff;
         seen_c  = seen_ff;
      end
   end

   // Number accumulate: saturate value*10, then saturate adding the digit.
   always_comb begin
      digit    = $signed({2'b00, ch_ff}) - 10'sd48;
      term     = neg_c ? -digit : digit;
      take_acc = !(!seen_c && ch_ff == CH_MINUS);
      acc_x    = ACC_BITS'(accum_c);
      mul_x    = (acc_x <<< 3) + (acc_x <<< 1);
      clip_in  = clip_c;
      if (mul_x > ACC_MAX) begin
         scaled_x = ACC_MAX;
         clip_in  = 1'b1;
      end else if (mul_x < ACC_MIN) begin
         scaled_x = ACC_MIN;
         clip_in  = 1'b1;
      end else begin
         scaled_x = mul_x;
      end
      sum_x = scaled_x + ACC_BITS'(term);
      if (sum_x > ACC_MAX) begin
         sum_x   = ACC_MAX;
         clip_in = 1'b1;
      end else if (sum_x < ACC_MIN) begin
         sum_x   = ACC_MIN;
         clip_in = 1'b1;
      end
      if (!take_acc) begin
         clip_in = clip_c;
      end
   end

   assign is_digit = (ch_ff >= CH_ZERO) && (ch_ff <= CH_NINE);

   always_comb begin
      mode_in  = mode_c;
      accum_in = accum_c;
      neg_in   = neg_c;
      seen_in  = seen_c;
      emit     = 1'b0;
      finish   = 1'b0;
      kind_in  = KIND_FALSE;
      value_in = '0;
      sat_in   = 1'b0;
      case (mode_c)
         MODE_STRING: begin
            emit = 1'b1;
            if (ch_ff == CH_QUOTE) begin
               kind_in = KIND_STR_END;
               finish  = 1'b1;
               mode_in = MODE_IDLE;
            end else begin
               kind_in  = KIND_STR_CHAR;
               value_in = VALUE_W'(ch_ff);
            end
         end
         MODE_HEAP, MODE_LOCAL: begin
            emit     = 1'b1;
            finish   = 1'b1;
            kind_in  = (mode_c == MODE_HEAP) ? KIND_HEAP_REF : KIND_LOCAL_REF;
            value_in = VALUE_W'(digit);
            mode_in  = MODE_IDLE;
         end
         MODE_NUMBER: begin
            if (ch_ff == CH_SPACE || ch_ff == CH_NEWLINE) begin
               emit     = 1'b1;
               finish   = 1'b1;
               kind_in  = KIND_INTEGER;
               value_in = VALUE_W'(accum_c);
               sat_in   = clip_c;
               mode_in  = MODE_IDLE;
               accum_in = '0;
               neg_in   = 1'b0;
               seen_in  = 1'b0;
            end else begin
               seen_in = 1'b1;
               if (take_acc) begin
                  accum_in = VALUE_BITS'(sum_x);
               end else begin
                  neg_in = 1'b1;
               end
            end
         end
         default: begin
            mode_in = MODE_IDLE;
            if (ch_ff == CH_QUOTE) begin
               mode_in = MODE_STRING;
            end else if (ch_ff == CH_AT) begin
               mode_in = MODE_HEAP;
            end else if (ch_ff == CH_DOLLAR) begin
               mode_in = MODE_LOCAL;
            end else if (ch_ff == CH_MINUS || is_digit) begin
               mode_in = MODE_NUMBER;
               seen_in = 1'b1;
               if (take_acc) begin
                  accum_in = VALUE_BITS'(sum_x);
               end else begin
                  neg_in = 1'b1;
               end
            end else if (ch_ff == CH_F || ch_ff == CH_T || ch_ff == CH_N) begin
               emit    = 1'b1;
               finish  = 1'b1;
               kind_in = (ch_ff == CH_F) ? KIND_FALSE :
                         (ch_ff == CH_T) ? KIND_TRUE : KIND_NULL;
            end
         end
      endcase
      if (mode_in != MODE_NUMBER) begin
         sat_in = (kind_in == KIND_INTEGER) ? clip_c : 1'b0;
      end
      count_in = (finish && !(&count_c)) ? count_c + 1'b1 : count_c;
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (process) begin
         out_valid_in = emit;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         mode_ff      <= MODE_IDLE;
         accum_ff     <= '0;
         neg_ff       <= 1'b0;
         clip_ff      <= 1'b0;
         seen_ff      <= 1'b0;
         count_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (process) begin
            mode_ff  <= mode_in;
            accum_ff <= accum_in;
            neg_ff   <= neg_in;
            clip_ff  <= (mode_in == MODE_NUMBER) ? clip_in : 1'b0;
            seen_ff  <= seen_in;
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         ch_ff         <= req_tdata;
         line_start_ff <= req_tuser[0];
      end
      if (process && emit) begin
         kind_ff  <= kind_in;
         value_ff <= value_in;
         index_ff <= INDEX_W'(count_c);
         sat_ff   <= sat_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {index_ff, value_ff};
   assign rsp_tuser  = {sat_ff, kind_ff};

endmodule

### hw/rtl/ats_checker.sv
module ats_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic [3:0]  rsp_tuser
);
   import ats_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp beat changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid after reset");

   a_ready_when_out_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("req_tready low with empty result register");

   a_zero_value: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser[2:0] == KIND_FALSE || rsp_tuser[2:0] == KIND_TRUE ||
      rsp_tuser[2:0] == KIND_NULL || rsp_tuser[2:0] == KIND_STR_END)
      |-> rsp_tdata[31:0] == '0)
      else $error("nonzero value on a token without value");

   a_sat_integer: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[3] |-> rsp_tuser[2:0] == KIND_INTEGER)
      else $error("saturated set on non-integer token");

   wire unused_req_tvalid = req_tvalid;

endmodule

bind argument_token_scanner_unit ats_checker u_ats_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
